/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by deadline_sorted_timer_queue_unit
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/dstq_pkg.sv */
// ----------------------------------------------------------------------------
// dstq_pkg
// types and constants of the deadline sorted timer queue
// ----------------------------------------------------------------------------
`default_nettype none

package dstq_pkg;

    localparam int ID_W   = 4;
    localparam int TMO_W  = 32;
    localparam int TIME_W = 48;
    localparam int MUL_W  = 10;
    localparam int PROD_W = TMO_W + MUL_W;

    localparam logic [MUL_W-1:0]  US_PER_MS = MUL_W'(1000);
    localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_STOP  = 2'd1;
    localparam logic [1:0] CMD_POLL  = 2'd2;

    localparam logic [2:0] ST_DONE       = 3'd0;
    localparam logic [2:0] ST_ACTIVE     = 3'd1;
    localparam logic [2:0] ST_NOT_QUEUED = 3'd2;
    localparam logic [2:0] ST_EXPIRED    = 3'd3;
    localparam logic [2:0] ST_NONE_DUE   = 3'd4;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE
    } t_op;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] dl;
    } t_entry;

    typedef struct packed {
        t_op               op;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] dl;
    } t_bcast;

endpackage

`default_nettype wire

/* rtl/dstq_cell.sv */
// ----------------------------------------------------------------------------
// dstq_cell
// one slot of the sorted chain: holds a timer id and its deadline, and
// shifts toward its neighbors on insert and remove
// ----------------------------------------------------------------------------
`default_nettype none

module dstq_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire dstq_pkg::t_bcast i_bc,
    input  wire logic            i_prev_le,
    input  wire dstq_pkg::t_entry i_left,
    input  wire dstq_pkg::t_entry i_right,
    input  wire logic            i_carry,
    output dstq_pkg::t_entry     o_entry,
    output logic                 o_le,
    output logic                 o_match,
    output logic                 o_carry
);
    import dstq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   w_shift;

    assign o_entry = r_entry;
    assign o_le    = r_entry.valid && (r_entry.dl <= i_bc.dl);
    assign o_match = r_entry.valid && (r_entry.id == i_bc.id);
    assign w_shift = i_carry || o_match;
    assign o_carry = w_shift;

    always_comb begin
        n_entry = r_entry;
        unique case (i_bc.op)
            OP_INSERT: begin
                if (!o_le) begin
                    if (i_prev_le) begin
                        n_entry = '{valid: 1'b1, id: i_bc.id, dl: i_bc.dl};
                    end else begin
                        n_entry = i_left;
                    end
                end
            end
            OP_REMOVE: begin
                if (w_shift) begin
                    n_entry = i_right;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.id <= n_entry.id;
        r_entry.dl <= n_entry.dl;
    end

endmodule

`default_nettype wire

/* rtl/deadline_sorted_timer_queue_unit.sv */
// ----------------------------------------------------------------------------
// deadline_sorted_timer_queue_unit
// one-shot timers kept in a chain of cells sorted by deadline; start, stop
// and poll commands, one result item per input item
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  in       input      i_valid / o_ready  command, timer_id, timeout_ms, now_us
//  out      output     o_valid / i_ready  status, expired_id, time_to_next_us,
//                                         queue_not_empty
//
//  an item runs 4 states: accept with timeout multiply, deadline add with
//  saturation, one chain update of all cells, head distance into the output
//  the result item is loaded into the output as the unit returns to idle,
//  and only then can the next item be accepted
//  a result waiting on i_ready lets the next item run up to the output load,
//  where it waits with o_ready low
//  synchronous active-low reset empties the chain
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module deadline_sorted_timer_queue_unit #(
    parameter int NUM_TIMERS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [1:0]                    i_command,
    input  wire logic [dstq_pkg::ID_W-1:0]     i_timer_id,
    input  wire logic [dstq_pkg::TMO_W-1:0]    i_timeout_ms,
    input  wire logic [dstq_pkg::TIME_W-1:0]   i_now_us,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [2:0]                         o_status,
    output logic [dstq_pkg::ID_W-1:0]          o_expired_id,
    output logic [dstq_pkg::TIME_W-1:0]        o_time_to_next_us,
    output logic                               o_queue_not_empty
);
    import dstq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_EXEC,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [1:0]           r_cmd;
    logic [ID_W-1:0]      r_id;
    logic [TIME_W-1:0]    r_now;
    logic [PROD_W-1:0]    r_prod;
    logic [TIME_W-1:0]    r_dl;
    logic [2:0]           r_status;
    logic [ID_W-1:0]      r_eid;

    t_bcast               w_bc;
    t_entry               w_entry [NUM_TIMERS];
    t_entry               w_left  [NUM_TIMERS];
    t_entry               w_right [NUM_TIMERS];
    logic                 w_prev_le [NUM_TIMERS];
    logic                 w_carry_in [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] w_le;
    logic [NUM_TIMERS-1:0] w_match;
    logic [NUM_TIMERS-1:0] w_carry;
    logic [NUM_TIMERS-1:0] w_valid;

    logic [TIME_W:0]      w_sum;
    logic                 w_hit;
    logic                 w_full;
    logic                 w_id_ok;
    logic                 w_head_due;
    logic                 w_load;
    logic [2:0]           n_status;
    logic [ID_W-1:0]      n_eid;
    t_op                  n_op;
    logic [TIME_W-1:0]    w_left_us;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_TIMERS; gi++) begin : g_cell
            if (gi == 0) begin : g_first
                assign w_left[gi]     = '0;
                assign w_prev_le[gi]  = 1'b1;
                assign w_carry_in[gi] = 1'b0;
            end else begin : g_mid
                assign w_left[gi]     = w_entry[gi-1];
                assign w_prev_le[gi]  = w_le[gi-1];
                assign w_carry_in[gi] = w_carry[gi-1];
            end
            if (gi == NUM_TIMERS - 1) begin : g_last
                assign w_right[gi] = '0;
            end else begin : g_inner
                assign w_right[gi] = w_entry[gi+1];
            end
            assign w_valid[gi] = w_entry[gi].valid;

            dstq_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_bc      (w_bc),
                .i_prev_le (w_prev_le[gi]),
                .i_left    (w_left[gi]),
                .i_right   (w_right[gi]),
                .i_carry   (w_carry_in[gi]),
                .o_entry   (w_entry[gi]),
                .o_le      (w_le[gi]),
                .o_match   (w_match[gi]),
                .o_carry   (w_carry[gi])
            );
        end
    endgenerate

    assign w_sum      = {1'b0, r_now} + (TIME_W + 1)'(r_prod);
    assign w_hit      = |w_match;
    assign w_full     = w_entry[NUM_TIMERS-1].valid;
    assign w_id_ok    = (32'(r_id) < NUM_TIMERS);
    assign w_head_due = w_entry[0].valid && (w_entry[0].dl <= r_now);
    assign w_left_us  = (w_entry[0].valid && (w_entry[0].dl > r_now))
                      ? (w_entry[0].dl - r_now) : '0;

    always_comb begin
        n_status = ST_NONE_DUE;
        n_eid    = '0;
        n_op     = OP_HOLD;
        unique case (r_cmd)
            CMD_START: begin
                priority if (!w_id_ok) begin
                    n_status = ST_NOT_QUEUED;
                end else if (w_hit || w_full) begin
                    n_status = ST_ACTIVE;
                end else begin
                    n_status = ST_DONE;
                    n_op     = OP_INSERT;
                end
            end
            CMD_STOP: begin
                if (w_id_ok && w_hit) begin
                    n_status = ST_DONE;
                    n_op     = OP_REMOVE;
                end else begin
                    n_status = ST_NOT_QUEUED;
                end
            end
            CMD_POLL: begin
                if (w_head_due) begin
                    n_status = ST_EXPIRED;
                    n_eid    = w_entry[0].id;
                    n_op     = OP_REMOVE;
                end
            end
            default: begin
                n_status = ST_NONE_DUE;
            end
        endcase
    end

    always_comb begin
        w_bc.op = (r_state == S_EXEC) ? n_op : OP_HOLD;
        w_bc.id = (r_cmd == CMD_POLL) ? w_entry[0].id : r_id;
        w_bc.dl = r_dl;
    end

    assign o_ready = (r_state == S_IDLE);
    assign w_load  = (r_state == S_DONE) && (!o_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (w_load) begin
                o_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        if (r_state == S_IDLE && i_valid) begin
            r_cmd  <= i_command;
            r_id   <= i_timer_id;
            r_now  <= i_now_us;
            r_prod <= PROD_W'(i_timeout_ms) * PROD_W'(US_PER_MS);
        end
        if (r_state == S_CALC) begin
            r_dl <= w_sum[TIME_W] ? TIME_MAX : w_sum[TIME_W-1:0];
        end
        if (r_state == S_EXEC) begin
            r_status <= n_status;
            r_eid    <= n_eid;
        end
        if (w_load) begin
            o_status          <= r_status;
            o_expired_id      <= r_eid;
            o_time_to_next_us <= w_left_us;
            o_queue_not_empty <= w_entry[0].valid;
        end
    end

    // queued entries form an unbroken run from the head
    `ASSERT_ALWAYS(a_chain_packed, i_clk, i_rst_n, (w_valid & (w_valid + 1'b1)) == '0)
    // a timer id sits in at most one cell
    `ASSERT_ALWAYS(a_id_unique, i_clk, i_rst_n, $onehot0(w_match))
    // a successful start adds exactly one entry
    `ASSERT_NEXT(a_start_adds, i_clk, i_rst_n,
        r_state == S_EXEC && r_cmd == CMD_START && n_status == ST_DONE,
        $countones(w_valid) == $past($countones(w_valid)) + 1)
    // a stop or expiry takes out exactly one entry
    `ASSERT_NEXT(a_remove_drops, i_clk, i_rst_n,
        r_state == S_EXEC && n_op == OP_REMOVE,
        $countones(w_valid) + 1 == $past($countones(w_valid)))

endmodule

`default_nettype wire

/* test/tb_deadline_sorted_timer_queue_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deadline_sorted_timer_queue_unit
// self-checking bench for the deadline sorted timer queue: a behavioral copy
// of the sorted timer list predicts every result item, directed tasks cover
// empty queue, expiry, ties, duplicates and saturation, then random traffic
// with fill and drain bursts and noise runs under random stalls on both sides
// ----------------------------------------------------------------------------
module tb_deadline_sorted_timer_queue_unit;

    import dstq_pkg::*;

    localparam int          TIMER_COUNT = 16;
    localparam int          ITEM_TARGET = 1050;
    localparam int          DRAIN_LIMIT = 20000;
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;

    typedef struct {
        logic [2:0]        status;
        logic [ID_W-1:0]   expired_id;
        logic [TIME_W-1:0] time_to_next;
        logic              not_empty;
    } t_timer_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [1:0]           i_command = CMD_POLL;
    logic [ID_W-1:0]      i_timer_id = '0;
    logic [TMO_W-1:0]     i_timeout_ms = '0;
    logic [TIME_W-1:0]    i_now_us = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [2:0]           o_status;
    logic [ID_W-1:0]      o_expired_id;
    logic [TIME_W-1:0]    o_time_to_next_us;
    logic                 o_queue_not_empty;

    // predicted timer list
    logic [TIME_W-1:0]    deadline_of [TIMER_COUNT];
    logic                 armed [TIMER_COUNT];
    logic [ID_W-1:0]      order_ids [TIMER_COUNT];
    int                   armed_count;

    t_timer_result        pending_results[$];
    logic [TIME_W-1:0]    wall_us;
    bit                   stall_off = 1'b0;
    int                   fail_count = 0;
    int                   items_sent = 0;
    int                   starts_sent = 0;
    int                   stops_sent = 0;
    int                   polls_sent = 0;
    int                   expiries_seen = 0;
    int                   saturated_starts = 0;

    deadline_sorted_timer_queue_unit #(
        .NUM_TIMERS(TIMER_COUNT)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_command(i_command),
        .i_timer_id(i_timer_id),
        .i_timeout_ms(i_timeout_ms),
        .i_now_us(i_now_us),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_status(o_status),
        .o_expired_id(o_expired_id),
        .o_time_to_next_us(o_time_to_next_us),
        .o_queue_not_empty(o_queue_not_empty)
    );

    always #4 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[TIME_W-1:0];
    endfunction

    function automatic void clear_timer_list();
        for (int i = 0; i < TIMER_COUNT; i++) begin
            deadline_of[i] = '0;
            armed[i] = 1'b0;
            order_ids[i] = '0;
        end
        armed_count = 0;
    endfunction

    function automatic void drop_slot(int pos);
        for (int i = pos; i + 1 < armed_count; i++) begin
            order_ids[i] = order_ids[i + 1];
        end
        armed_count--;
    endfunction

    function automatic t_timer_result apply_timer_cmd(logic [1:0] cmd, logic [ID_W-1:0] id,
                                                      logic [TMO_W-1:0] tmo,
                                                      logic [TIME_W-1:0] now);
        t_timer_result     r;
        logic [63:0]       sum;
        logic [TIME_W-1:0] dl;
        logic [ID_W-1:0]   head;
        int                pos;
        r.status = ST_NONE_DUE;
        r.expired_id = '0;
        r.time_to_next = '0;
        case (cmd)
            CMD_START: begin
                if (armed[id] || armed_count >= TIMER_COUNT) begin
                    r.status = ST_ACTIVE;
                end else begin
                    sum = 64'(now) + 64'(tmo) * 64'(US_PER_MS);
                    if (sum > 64'(TIME_MAX)) begin
                        dl = TIME_MAX;
                        saturated_starts++;
                    end else begin
                        dl = sum[TIME_W-1:0];
                    end
                    pos = 0;
                    while (pos < armed_count && deadline_of[order_ids[pos]] <= dl) begin
                        pos++;
                    end
                    for (int i = armed_count; i > pos; i--) begin
                        order_ids[i] = order_ids[i - 1];
                    end
                    order_ids[pos] = id;
                    armed_count++;
                    deadline_of[id] = dl;
                    armed[id] = 1'b1;
                    r.status = ST_DONE;
                end
            end
            CMD_STOP: begin
                if (!armed[id]) begin
                    r.status = ST_NOT_QUEUED;
                end else begin
                    for (int i = 0; i < armed_count; i++) begin
                        if (order_ids[i] == id) begin
                            drop_slot(i);
                            break;
                        end
                    end
                    armed[id] = 1'b0;
                    deadline_of[id] = '0;
                    r.status = ST_DONE;
                end
            end
            CMD_POLL: begin
                if (armed_count > 0) begin
                    head = order_ids[0];
                    if (deadline_of[head] <= now) begin
                        drop_slot(0);
                        armed[head] = 1'b0;
                        deadline_of[head] = '0;
                        r.expired_id = head;
                        r.status = ST_EXPIRED;
                        expiries_seen++;
                    end
                end
            end
            default: begin
            end
        endcase
        if (armed_count > 0 && deadline_of[order_ids[0]] > now) begin
            r.time_to_next = deadline_of[order_ids[0]] - now;
        end
        r.not_empty = (armed_count > 0);
        return r;
    endfunction

    task automatic send_timer_item(logic [1:0] cmd, logic [ID_W-1:0] id,
                                   logic [TMO_W-1:0] tmo, logic [TIME_W-1:0] now);
        int gap;
        gap = stall_off ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_timer_id <= id;
        i_timeout_ms <= tmo;
        i_now_us <= now;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_results.push_back(apply_timer_cmd(cmd, id, tmo, now));
        items_sent++;
        case (cmd)
            CMD_START: starts_sent++;
            CMD_STOP:  stops_sent++;
            CMD_POLL:  polls_sent++;
            default: begin
            end
        endcase
    endtask

    task automatic send_mixed_item();
        int               r;
        logic [TMO_W-1:0] tmo;
        r = $urandom_range(0, 99);
        wall_us = wall_us + TIME_W'($urandom_range(0, 1500));
        tmo = ($urandom_range(0, 19) == 0) ? TMO_W'($urandom()) : TMO_W'($urandom_range(0, 12));
        if (r < 40) begin
            send_timer_item(CMD_START, ID_W'($urandom()), tmo, wall_us);
        end else if (r < 60) begin
            send_timer_item(CMD_STOP, ID_W'($urandom()), TMO_W'($urandom()), wall_us);
        end else if (r < 95) begin
            send_timer_item(CMD_POLL, ID_W'($urandom()), TMO_W'($urandom()), wall_us);
        end else begin
            send_timer_item(CMD_UNUSED, ID_W'($urandom()), TMO_W'($urandom()), wall_us);
        end
    endtask

    task automatic send_noise_item();
        send_timer_item(2'($urandom()), ID_W'($urandom()), TMO_W'($urandom()), rand_time());
    endtask

    task automatic test_empty_queue();
        wall_us = 48'h0000_1234_5678;
        send_timer_item(CMD_POLL, 4'd0, '0, wall_us);
        send_timer_item(CMD_STOP, 4'd15, '0, wall_us);
        send_timer_item(CMD_UNUSED, 4'd10, '1, wall_us);
    endtask

    task automatic test_start_and_expire();
        send_timer_item(CMD_START, 4'd0, '0, wall_us);
        send_timer_item(CMD_POLL, 4'd0, '0, wall_us);
        send_timer_item(CMD_START, 4'd5, 32'd2, wall_us);
        send_timer_item(CMD_POLL, 4'd0, '0, wall_us + 48'd1999);
        send_timer_item(CMD_POLL, 4'd0, '0, wall_us + 48'd2000);
        wall_us = wall_us + 48'd2000;
    endtask

    task automatic test_ties_and_duplicates();
        send_timer_item(CMD_START, 4'd3, 32'd5, wall_us);
        send_timer_item(CMD_START, 4'd3, 32'd9, wall_us);
        send_timer_item(CMD_START, 4'd7, 32'd5, wall_us);
        send_timer_item(CMD_START, 4'd1, 32'd1, wall_us);
        send_timer_item(CMD_STOP, 4'd3, '0, wall_us);
        send_timer_item(CMD_STOP, 4'd3, '0, wall_us);
        wall_us = wall_us + 48'd10000;
        send_timer_item(CMD_POLL, 4'd0, '0, wall_us);
        send_timer_item(CMD_POLL, 4'd0, '0, wall_us);
        send_timer_item(CMD_POLL, 4'd0, '0, wall_us);
    endtask

    task automatic test_saturation();
        send_timer_item(CMD_START, 4'd15, '1, TIME_MAX);
        send_timer_item(CMD_START, 4'd8, '1, '0);
        send_timer_item(CMD_POLL, 4'd0, '0, TIME_MAX);
        send_timer_item(CMD_POLL, 4'd0, '0, TIME_MAX);
    endtask

    task automatic test_back_to_back();
        stall_off = 1'b1;
        repeat (40) send_mixed_item();
        stall_off = 1'b0;
    endtask

    task automatic test_random_traffic();
        int pick;
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                wall_us = TIME_MAX - TIME_W'($urandom_range(0, 40000));
            end else if (pick == 1) begin
                wall_us = rand_time();
            end else if (pick < 5) begin
                // fill the list, then drain it as time moves on
                repeat (18) begin
                    send_timer_item(CMD_START, ID_W'($urandom()),
                                    TMO_W'($urandom_range(0, 20)), wall_us);
                end
                repeat (24) begin
                    wall_us = wall_us + TIME_W'($urandom_range(0, 2000));
                    send_timer_item(CMD_POLL, '0, '0, wall_us);
                end
            end else if (pick < 7) begin
                repeat (8) send_noise_item();
            end else begin
                repeat (20) send_mixed_item();
            end
        end
    endtask

    initial begin
        clear_timer_list();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_queue();
        test_start_and_expire();
        test_ties_and_duplicates();
        test_saturation();
        test_back_to_back();
        test_random_traffic();
        i_valid <= 1'b0;
        for (int w = 0; w < DRAIN_LIMIT && pending_results.size() > 0; w++) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d result items never arrived", pending_results.size());
            fail_count++;
        end
        $display("ran %0d items: %0d starts, %0d stops, %0d polls", items_sent, starts_sent,
                 stops_sent, polls_sent);
        $display("timers expired: %0d, saturated deadlines: %0d, errors: %0d", expiries_seen,
                 saturated_starts, fail_count);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // result side backpressure
    initial begin
        int gap;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = stall_off ? 0 : pick_gap();
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_timer_result exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result item with no item pending");
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, o_status);
                    fail_count++;
                end
                if (o_expired_id !== exp_r.expired_id) begin
                    $error("expired_id: expected %0d, got %0d", exp_r.expired_id, o_expired_id);
                    fail_count++;
                end
                if (o_time_to_next_us !== exp_r.time_to_next) begin
                    $error("time_to_next_us: expected %0d, got %0d", exp_r.time_to_next,
                           o_time_to_next_us);
                    fail_count++;
                end
                if (o_queue_not_empty !== exp_r.not_empty) begin
                    $error("queue_not_empty: expected %0d, got %0d", exp_r.not_empty,
                           o_queue_not_empty);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
